// ===== rtl/core/line_plane_intersection_param_macros.svh =====
// assertion macros shared by the intersection pipeline
`ifndef LINE_PLANE_INTERSECTION_PARAM_MACROS_SVH
`define LINE_PLANE_INTERSECTION_PARAM_MACROS_SVH

// same-cycle implication
`define LPI_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LPI_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/lpi_pkg.sv =====
// shared types, constants and width helpers for the line/plane intersection block
`timescale 1ns / 1ps
package lpi_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FIELD_W         = 32;
    localparam int T_W             = 64;
    localparam int THR_W           = 63;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_IDX_W       = 3;
    localparam int FRAC_SHIFT      = 32;
    localparam int Q_BITS          = 65;
    localparam logic [THR_W-1:0] THR_RESET = 63'd28147;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_X = 3'd0,
        CFG_START_Y = 3'd1,
        CFG_START_Z = 3'd2,
        CFG_END_X   = 3'd3,
        CFG_END_Y   = 3'd4,
        CFG_END_Z   = 3'd5,
        CFG_THRESH  = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] pa_x;
        logic signed [FIELD_W-1:0] pa_y;
        logic signed [FIELD_W-1:0] pa_z;
        logic signed [FIELD_W-1:0] pb_x;
        logic signed [FIELD_W-1:0] pb_y;
        logic signed [FIELD_W-1:0] pb_z;
        logic signed [FIELD_W-1:0] pc_x;
        logic signed [FIELD_W-1:0] pc_y;
        logic signed [FIELD_W-1:0] pc_z;
    } in_item_t;

    typedef struct packed {
        logic signed [T_W-1:0] t_param;
        logic                  degenerate;
        logic                  saturated;
    } out_item_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] sx;
        logic signed [FIELD_W-1:0] sy;
        logic signed [FIELD_W-1:0] sz;
        logic signed [FIELD_W-1:0] ex;
        logic signed [FIELD_W-1:0] ey;
        logic signed [FIELD_W-1:0] ez;
    } line_t;

    // pipeline control between the determinant and divider sections
    typedef struct packed {
        logic adv;
        logic vld;
    } pipe_ctl_t;

    // width of the exact determinants for a given coordinate width
    function automatic int lpi_det_width(input int cw);
        return 3 * (cw + 1) + 3;
    endfunction

endpackage

// ===== rtl/core/line_plane_intersection_param.sv =====
// line/plane intersection top level: line registers, pipeline control, result port
// stages: 6 determinant stages, 2 setup stages, 65 divider stages and 1 output stage
// throughput: one plane per cycle; the whole pipeline holds while a result waits
// reset: clears all valid bits, line points to zero and the threshold to 28147
`timescale 1ns / 1ps
module line_plane_intersection_param #(
    parameter int COORD_WIDTH = lpi_pkg::COORD_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  lpi_pkg::in_item_t                   s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output lpi_pkg::out_item_t                  m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lpi_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lpi_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import lpi_pkg::*;

    `include "line_plane_intersection_param_macros.svh"

    localparam int TW = lpi_det_width(COORD_WIDTH);

    line_t            line_reg;
    logic [THR_W-1:0] thr_reg;
    pipe_ctl_t        ctl_in, ctl_mid;
    logic             det_vld;
    logic signed [TW-1:0] t1, t2;

    // single advance for every stage; the output register frees on a transfer
    assign s_ready    = !m_valid || m_ready;
    assign cfg_ready  = 1'b1;
    assign ctl_in.adv = s_ready;
    assign ctl_in.vld = s_valid;
    assign ctl_mid.adv = s_ready;
    assign ctl_mid.vld = det_vld;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_reg <= '0;
            thr_reg  <= THR_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_START_X: line_reg.sx <= cfg_data[FIELD_W-1:0];
                CFG_START_Y: line_reg.sy <= cfg_data[FIELD_W-1:0];
                CFG_START_Z: line_reg.sz <= cfg_data[FIELD_W-1:0];
                CFG_END_X:   line_reg.ex <= cfg_data[FIELD_W-1:0];
                CFG_END_Y:   line_reg.ey <= cfg_data[FIELD_W-1:0];
                CFG_END_Z:   line_reg.ez <= cfg_data[FIELD_W-1:0];
                CFG_THRESH:  thr_reg     <= cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    lpi_det #(
        .CW (COORD_WIDTH),
        .TW (TW)
    ) u_det (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl_in  (ctl_in),
        .item    (s_data),
        .line    (line_reg),
        .out_vld (det_vld),
        .t1      (t1),
        .t2      (t2)
    );

    lpi_div #(
        .TW (TW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl_in   (ctl_mid),
        .t1       (t1),
        .t2       (t2),
        .thr      (thr_reg),
        .out_vld  (m_valid),
        .out_item (m_data)
    );

    `LPI_ASSERT_IMP(a_degen_clean, aclk, aresetn, m_valid && m_data.degenerate, m_data.t_param == '0 && !m_data.saturated, "degenerate result carries a value")
    `LPI_ASSERT_IMP(a_sat_clamp, aclk, aresetn, m_valid && m_data.saturated, m_data.t_param == 64'h7FFF_FFFF_FFFF_FFFF || m_data.t_param == 64'h8000_0000_0000_0000, "saturated result not at a limit")
    `LPI_ASSERT_NXT(a_thr_write, aclk, aresetn, cfg_valid && cfg_ready && cfg_index == CFG_THRESH, thr_reg == $past(cfg_data[THR_W-1:0]), "threshold write lost")

endmodule

// ===== rtl/core/lpi_det.sv =====
// six-stage pipeline forming the volume and direction determinants exactly
`timescale 1ns / 1ps
module lpi_det #(
    parameter int CW = lpi_pkg::COORD_WIDTH_DEF,
    parameter int TW = lpi_pkg::lpi_det_width(CW)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  lpi_pkg::pipe_ctl_t    ctl_in,
    input  lpi_pkg::in_item_t     item,
    input  lpi_pkg::line_t        line,
    output logic                  out_vld,
    output logic signed [TW-1:0]  t1,
    output logic signed [TW-1:0]  t2
);
    import lpi_pkg::*;

    localparam int DW = CW + 1;
    localparam int PW = 2 * DW;
    localparam int NW = PW + 1;
    localparam int LO = NW - DW;
    localparam int LPW = LO + 1 + DW;
    localparam int NSTG = 6;

    logic [NSTG-1:0] vld_reg;

    logic signed [DW-1:0] a [3], b [3], c [3], s [3], e [3];
    logic signed [DW-1:0] u_next [3], v_next [3], w_next [3], d_next [3];
    logic signed [DW-1:0] u_reg [3], v_reg [3], w1_reg [3], d1_reg [3];
    logic signed [PW-1:0] m_next [6], m_reg [6];
    logic signed [DW-1:0] w2_reg [3], d2_reg [3];
    logic signed [NW-1:0] n_next [3], n_reg [3];
    logic signed [DW-1:0] w3_reg [3], d3_reg [3];
    logic signed [LPW-1:0] plo_next [6], plo_reg [6];
    logic signed [PW-1:0]  phi_next [6], phi_reg [6];
    logic signed [TW-1:0]  p_next [6], p_reg [6];
    logic signed [TW-1:0]  t1_next, t2_next, t1_reg, t2_reg;

    always_comb begin
        a[0] = DW'(signed'(item.pa_x[CW-1:0]));
        a[1] = DW'(signed'(item.pa_y[CW-1:0]));
        a[2] = DW'(signed'(item.pa_z[CW-1:0]));
        b[0] = DW'(signed'(item.pb_x[CW-1:0]));
        b[1] = DW'(signed'(item.pb_y[CW-1:0]));
        b[2] = DW'(signed'(item.pb_z[CW-1:0]));
        c[0] = DW'(signed'(item.pc_x[CW-1:0]));
        c[1] = DW'(signed'(item.pc_y[CW-1:0]));
        c[2] = DW'(signed'(item.pc_z[CW-1:0]));
        s[0] = DW'(signed'(line.sx[CW-1:0]));
        s[1] = DW'(signed'(line.sy[CW-1:0]));
        s[2] = DW'(signed'(line.sz[CW-1:0]));
        e[0] = DW'(signed'(line.ex[CW-1:0]));
        e[1] = DW'(signed'(line.ey[CW-1:0]));
        e[2] = DW'(signed'(line.ez[CW-1:0]));
        for (int i = 0; i < 3; i++) begin
            u_next[i] = b[i] - a[i];
            v_next[i] = c[i] - a[i];
            w_next[i] = s[i] - a[i];
            d_next[i] = e[i] - s[i];
        end
    end

    // cross product partial terms
    always_comb begin
        m_next[0] = u_reg[1] * v_reg[2];
        m_next[1] = u_reg[2] * v_reg[1];
        m_next[2] = u_reg[2] * v_reg[0];
        m_next[3] = u_reg[0] * v_reg[2];
        m_next[4] = u_reg[0] * v_reg[1];
        m_next[5] = u_reg[1] * v_reg[0];
        for (int i = 0; i < 3; i++) begin
            n_next[i] = NW'(m_reg[2*i]) - NW'(m_reg[2*i+1]);
        end
    end

    // normal times w and d, split into a low unsigned and a high signed half
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            plo_next[i]     = signed'({1'b0, n_reg[i][LO-1:0]}) * w3_reg[i];
            plo_next[i + 3] = signed'({1'b0, n_reg[i][LO-1:0]}) * d3_reg[i];
            phi_next[i]     = signed'(n_reg[i][NW-1:LO]) * w3_reg[i];
            phi_next[i + 3] = signed'(n_reg[i][NW-1:LO]) * d3_reg[i];
        end
        for (int k = 0; k < 6; k++) begin
            p_next[k] = (TW'(phi_reg[k]) <<< LO) + TW'(plo_reg[k]);
        end
        t1_next = p_reg[0] + p_reg[1] + p_reg[2];
        t2_next = p_reg[3] + p_reg[4] + p_reg[5];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ctl_in.adv) begin
            vld_reg <= {vld_reg[NSTG-2:0], ctl_in.vld};
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl_in.adv) begin
            for (int i = 0; i < 3; i++) begin
                u_reg[i]  <= u_next[i];
                v_reg[i]  <= v_next[i];
                w1_reg[i] <= w_next[i];
                d1_reg[i] <= d_next[i];
                w2_reg[i] <= w1_reg[i];
                d2_reg[i] <= d1_reg[i];
                n_reg[i]  <= n_next[i];
                w3_reg[i] <= w2_reg[i];
                d3_reg[i] <= d2_reg[i];
            end
            for (int k = 0; k < 6; k++) begin
                m_reg[k]   <= m_next[k];
                plo_reg[k] <= plo_next[k];
                phi_reg[k] <= phi_next[k];
                p_reg[k]   <= p_next[k];
            end
            t1_reg <= t1_next;
            t2_reg <= t2_next;
        end
    end

    assign out_vld = vld_reg[NSTG-1];
    assign t1      = t1_reg;
    assign t2      = t2_reg;

endmodule

// ===== rtl/core/lpi_div.sv =====
// pipelined restoring divider, one quotient bit per stage, with clamping
`timescale 1ns / 1ps
module lpi_div #(
    parameter int TW = lpi_pkg::lpi_det_width(lpi_pkg::COORD_WIDTH_DEF)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  lpi_pkg::pipe_ctl_t            ctl_in,
    input  logic signed [TW-1:0]          t1,
    input  logic signed [TW-1:0]          t2,
    input  logic [lpi_pkg::THR_W-1:0]     thr,
    output logic                          out_vld,
    output lpi_pkg::out_item_t            out_item
);
    import lpi_pkg::*;

    localparam int QB   = Q_BITS;
    localparam int RW   = TW + 1;
    localparam int NUMW = (TW + FRAC_SHIFT > QB) ? TW + FRAC_SHIFT : QB + 1;
    localparam int CMPW = (TW > THR_W) ? TW : THR_W;
    localparam int NSTG = QB + 3;
    localparam logic [QB-1:0] LIM = QB'(1) << (T_W - 1);

    logic [NSTG-1:0] vld_reg;

    // magnitude stage
    logic [TW-1:0] mag1_next, mag2_next, mag1_reg, mag2_reg;
    logic          neg_next, neg_a_reg;

    // setup stage
    logic [NUMW-1:0] num;
    logic [RW-1:0]   rem0;
    logic            degen_next;

    // divider stages, index 0 is the setup output
    logic [RW-1:0] rem_reg [QB+1];
    logic [QB-1:0] qn_reg  [QB+1];
    logic [TW-1:0] den_reg [QB+1];
    logic          neg_reg [QB+1];
    logic          ovf_reg [QB+1];
    logic          dgn_reg [QB+1];
    logic [RW-1:0] sh [QB+1];
    logic          ge [QB+1];

    logic [QB-1:0] q;
    logic          neg_eff, sat, q_zero;
    logic [QB-1:0] mag;
    out_item_t     res_next, res_reg;

    always_comb begin
        mag1_next = t1[TW-1] ? TW'(-t1) : TW'(t1);
        mag2_next = t2[TW-1] ? TW'(-t2) : TW'(t2);
        neg_next  = (t1[TW-1] == t2[TW-1]);
        num        = NUMW'(mag1_reg) << FRAC_SHIFT;
        rem0       = RW'(num >> QB);
        degen_next = CMPW'(mag2_reg) <= CMPW'(thr);
    end

    always_comb begin
        sh[0] = '0;
        ge[0] = 1'b0;
        for (int j = 1; j <= QB; j++) begin
            sh[j] = {rem_reg[j-1][RW-2:0], qn_reg[j-1][QB-1]};
            ge[j] = sh[j] >= RW'(den_reg[j-1]);
        end
    end

    // sign and range of the final quotient
    always_comb begin
        q       = qn_reg[QB];
        q_zero  = (q == '0) && !ovf_reg[QB];
        neg_eff = neg_reg[QB] && !q_zero;
        if (neg_eff) begin
            sat = ovf_reg[QB] || (q > LIM);
            mag = sat ? LIM : q;
        end else begin
            sat = ovf_reg[QB] || (q >= LIM);
            mag = sat ? LIM - QB'(1) : q;
        end
        if (dgn_reg[QB]) begin
            res_next.t_param    = '0;
            res_next.degenerate = 1'b1;
            res_next.saturated  = 1'b0;
        end else begin
            res_next.t_param    = neg_eff ? -signed'(mag[T_W-1:0]) : signed'(mag[T_W-1:0]);
            res_next.degenerate = 1'b0;
            res_next.saturated  = sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ctl_in.adv) begin
            vld_reg <= {vld_reg[NSTG-2:0], ctl_in.vld};
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl_in.adv) begin
            mag1_reg  <= mag1_next;
            mag2_reg  <= mag2_next;
            neg_a_reg <= neg_next;
            // remaining numerator bits sit on top of qn, quotient bits fill in below
            rem_reg[0] <= rem0;
            qn_reg[0]  <= num[QB-1:0];
            den_reg[0] <= mag2_reg;
            neg_reg[0] <= neg_a_reg;
            ovf_reg[0] <= rem0 >= RW'(mag2_reg);
            dgn_reg[0] <= degen_next;
            for (int j = 1; j <= QB; j++) begin
                rem_reg[j] <= ge[j] ? sh[j] - RW'(den_reg[j-1]) : sh[j];
                qn_reg[j]  <= {qn_reg[j-1][QB-2:0], ge[j]};
                den_reg[j] <= den_reg[j-1];
                neg_reg[j] <= neg_reg[j-1];
                ovf_reg[j] <= ovf_reg[j-1];
                dgn_reg[j] <= dgn_reg[j-1];
            end
            res_reg <= res_next;
        end
    end

    assign out_vld  = vld_reg[NSTG-1];
    assign out_item = res_reg;

endmodule
